@@ rtl/sle_pkg.sv @@
// Shared types, constants and codes for the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

   // Storage shape of the list.
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CELL_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // Field widths of the two channels.
   localparam int OP_W     = 3;
   localparam int IDX_W    = 4;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
   localparam logic [OP_W-1:0] OP_GET     = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Sequencer states: the second pass of a replace is a state of its own.
   typedef enum logic {
      ST_IDLE,
      ST_REINSERT
   } sle_state_type;

   // Control broadcast to every cell of the row.
   typedef struct packed {
      logic              ins_en;
      logic              rem_en;
      value_type         value;
      logic [CELL_W-1:0] index;
      logic [CNT_W-1:0]  count;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ rtl/sle_if.sv @@
// Request and response channel interfaces of the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none

interface sle_req_if import sle_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic signed [31:0]     value;
   logic [IDX_W-1:0]       index;

   modport source (output valid, output operation, output value, output index,
                   input ready);
   modport sink   (input valid, input operation, input value, input index,
                   output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [POS_W-1:0]       position;
   logic signed [31:0]     element;
   logic                   found;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_W-1:0]     count;

   modport source (output valid, output position, output element, output found,
                   output status, output count, input ready);
   modport sink   (input valid, input position, input element, input found,
                   input status, input count, output ready);
endinterface

`default_nettype wire

@@ rtl/sorted_list_engine.sv @@
// Top level of the sorted list engine: sequencer, cell row and response register.
//
//   Channel    Direction  Content
//   req_chan   in         operation, value, index
//   rsp_chan   out        position, element, found, status, count
//
// Every operation but a successful replace makes one pass through the cell row; such a
// replace makes two, a removal pass and then an insertion pass through the cell row.
// Reset clears the fill count, the sequencer and the response valid; entries
// hold whatever they last held. A response waits in its register until taken,
// and a new request is taken in the same cycle that the waiting one transfers.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine import sle_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sle_req_if.sink  req_chan,
   sle_rsp_if.source rsp_chan
);

   sle_state_type     state_ff;
   sle_state_type     state_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   value_type         value_ff;
   logic              rsp_valid_ff;
   logic [POS_W-1:0]  position_ff;
   value_type         element_ff;
   logic              found_ff;
   logic [STATUS_W-1:0] status_ff;

   logic              req_fire;
   logic              idx_ok;
   logic              full;
   logic              rsp_load;
   logic [POS_W-1:0]  rsp_position;
   value_type         rsp_element;
   logic              rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   cell_ctl_type      ctl;

   value_type         cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_lt;
   logic [CAPACITY-1:0] cell_eq;
   logic [CAPACITY:0] lt_ext;
   logic [CELL_W-1:0] ins_pos;
   value_type         read_entry;

   // Handshake.
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign idx_ok         = (CNT_W'(req_chan.index) < count_ff);
   assign full           = (count_ff == CNT_W'(CAPACITY));

   // Row of cells.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      left_lt;
      value_type left_entry;
      value_type right_entry;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = '0;
      end else begin : g_inner
         assign left_lt    = cell_lt[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .cell_index  (CELL_W'(i)),
         .ctl         (ctl),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i])
      );
   end

   // The less-than flags form a prefix; the slot sits just past its end.
   assign lt_ext = {1'b0, cell_lt};

   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lt_ext[i] && !lt_ext[i+1]) begin
            ins_pos = ins_pos | CELL_W'(i + 1);
         end
      end
   end

   // Entry at the requested index.
   always_comb begin
      read_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CELL_W'(i) == CELL_W'(req_chan.index)) begin
            read_entry = read_entry | cell_entry[i];
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.operation == OP_REPLACE) && idx_ok) begin
               state_in = ST_REINSERT;
            end
         end
         ST_REINSERT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: cell control, fill count and response contents.
   always_comb begin
      ctl.ins_en   = 1'b0;
      ctl.rem_en   = 1'b0;
      ctl.value    = req_chan.value;
      ctl.index    = CELL_W'(req_chan.index);
      ctl.count    = count_ff;
      count_in     = count_ff;
      rsp_load     = 1'b0;
      rsp_position = '0;
      rsp_element  = '0;
      rsp_found    = 1'b0;
      rsp_status   = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               case (req_chan.operation)
                  OP_INSERT: begin
                     if (full) begin
                        rsp_status = STATUS_FULL;
                     end else begin
                        ctl.ins_en   = 1'b1;
                        count_in     = count_ff + 1'b1;
                        rsp_position = POS_W'(ins_pos);
                     end
                  end
                  OP_REMOVE: begin
                     if (idx_ok) begin
                        ctl.rem_en = 1'b1;
                        count_in   = count_ff - 1'b1;
                     end else begin
                        rsp_status = STATUS_BAD_INDEX;
                     end
                  end
                  OP_REPLACE: begin
                     if (idx_ok) begin
                        ctl.rem_en = 1'b1;
                        count_in   = count_ff - 1'b1;
                        rsp_load   = 1'b0;
                     end else begin
                        rsp_status = STATUS_BAD_INDEX;
                     end
                  end
                  OP_GET: begin
                     if (idx_ok) begin
                        rsp_element = read_entry;
                     end else begin
                        rsp_status = STATUS_BAD_INDEX;
                     end
                  end
                  OP_FIND: begin
                     rsp_found = |cell_eq;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REINSERT: begin
            ctl.value    = value_ff;
            ctl.ins_en   = 1'b1;
            count_in     = count_ff + 1'b1;
            rsp_load     = 1'b1;
            rsp_position = POS_W'(ins_pos);
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload and the value held over for the second replace pass.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         value_ff <= req_chan.value;
      end
      if (rsp_load) begin
         position_ff <= rsp_position;
         element_ff  <= rsp_element;
         found_ff    <= rsp_found;
         status_ff   <= rsp_status;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.position = position_ff;
   assign rsp_chan.element  = element_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.count    = COUNT_W'(count_ff);

endmodule

`default_nettype wire

@@ rtl/sle_cell.sv @@
// One storage cell of the sorted list: holds one entry and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module sle_cell import sle_pkg::*; (
   input  wire logic              clock,
   input  wire logic [CELL_W-1:0] cell_index,
   input  wire cell_ctl_type      ctl,
   input  wire logic              left_lt,
   input  wire value_type         left_entry,
   input  wire value_type         right_entry,
   output      value_type         entry,
   output      logic              lt,
   output      logic              eq
);

   value_type entry_ff;
   value_type entry_in;
   logic      valid;

   // The cell holds a live entry when it lies below the fill count.
   assign valid = (CNT_W'(cell_index) < ctl.count);

   // Parallel compares against the broadcast value.
   assign lt    = valid && (ctl.value > entry_ff);
   assign eq    = valid && (ctl.value == entry_ff);
   assign entry = entry_ff;

   // Insert: cells below the slot keep, the slot loads, the rest shift right.
   // Remove: cells from the index upwards take their right neighbour.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         if (lt) begin
            entry_in = entry_ff;
         end else if (left_lt) begin
            entry_in = ctl.value;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.rem_en) begin
         if (cell_index >= ctl.index) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ tb/sorted_list_checker.sv @@
// Checker for the sorted list engine: predicts every response and compares it field by field.
`timescale 1ns / 1ps

module sorted_list_checker import sle_pkg::*; (
   input  logic clock,
   input  logic reset,
   sle_req_if   req_mon,
   sle_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   results_checked,
   output int   model_fill,
   output int   full_refusals,
   output int   bad_index_refusals,
   output int   find_hits,
   output int   replace_moves
);

   // One awaited response, with the operation that caused it kept for messages.
   typedef struct {
      logic [OP_W-1:0]     op;
      logic [POS_W-1:0]    position;
      value_type           element;
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } list_result_type;

   list_result_type awaited_results[$];

   // Shadow copy of the list: only entries below fill are ever meaningful.
   value_type sorted_vals[CAPACITY];
   int        fill;

   initial begin
      fail_count         = 0;
      pending_count      = 0;
      results_checked    = 0;
      model_fill         = 0;
      full_refusals      = 0;
      bad_index_refusals = 0;
      find_hits          = 0;
      replace_moves      = 0;
      fill               = 0;
   end

   task automatic report_error(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      fail_count++;
   endtask

   // Closes the gap left by the entry at the given position.
   function automatic void drop_entry(int at);
      for (int k = at; k + 1 < fill; k++) begin
         sorted_vals[k] = sorted_vals[k + 1];
      end
      fill--;
   endfunction

   // A new value goes in front of the first stored value that is not smaller.
   function automatic int place_value(value_type v);
      int pos;
      pos = 0;
      while (pos < fill && v > sorted_vals[pos]) begin
         pos++;
      end
      for (int k = fill; k > pos; k--) begin
         sorted_vals[k] = sorted_vals[k - 1];
      end
      sorted_vals[pos] = v;
      fill++;
      return pos;
   endfunction

   // Applies one operation to the shadow list and returns the response it should give.
   function automatic list_result_type predict_list_op(logic [OP_W-1:0] op, value_type v,
                                                       logic [IDX_W-1:0] idx);
      list_result_type r;
      r.op       = op;
      r.position = '0;
      r.element  = '0;
      r.found    = 1'b0;
      r.status   = STATUS_OK;
      case (op)
         OP_INSERT: begin
            if (fill >= CAPACITY) begin
               r.status = STATUS_FULL;
               full_refusals++;
            end else begin
               r.position = POS_W'(place_value(v));
            end
         end
         OP_REMOVE, OP_REPLACE, OP_GET: begin
            if (int'(idx) >= fill) begin
               r.status = STATUS_BAD_INDEX;
               bad_index_refusals++;
            end else if (op == OP_GET) begin
               r.element = sorted_vals[idx];
            end else begin
               drop_entry(int'(idx));
               if (op == OP_REPLACE) begin
                  r.position = POS_W'(place_value(v));
                  replace_moves++;
               end
            end
         end
         OP_FIND: begin
            for (int k = 0; k < fill; k++) begin
               if (sorted_vals[k] == v) r.found = 1'b1;
            end
            if (r.found) find_hits++;
         end
         OP_CLEAR: begin
            fill = 0;
         end
         default: begin
            // Spare operation codes leave the list alone.
         end
      endcase
      r.count = COUNT_W'(fill);
      return r;
   endfunction

   task automatic compare_response(list_result_type want);
      string tag;
      tag = $sformatf("response %0d (op %0d)", results_checked, want.op);
      if (rsp_mon.position !== want.position)
         report_error($sformatf("%s position: expected %0d, got %0d", tag,
                                want.position, rsp_mon.position));
      if (rsp_mon.element !== want.element)
         report_error($sformatf("%s element: expected %0d, got %0d", tag,
                                want.element, rsp_mon.element));
      if (rsp_mon.found !== want.found)
         report_error($sformatf("%s found: expected %0b, got %0b", tag,
                                want.found, rsp_mon.found));
      if (rsp_mon.status !== want.status)
         report_error($sformatf("%s status: expected %0d, got %0d", tag,
                                want.status, rsp_mon.status));
      if (rsp_mon.count !== want.count)
         report_error($sformatf("%s count: expected %0d, got %0d", tag,
                                want.count, rsp_mon.count));
   endtask

   // Responses are checked before the request of the same edge is predicted, since a
   // response can never belong to a request taken in the same cycle.
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         fill = 0;
         awaited_results.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
               report_error("response transfer with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               compare_response(want);
               results_checked++;
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            awaited_results.push_back(predict_list_op(req_mon.operation, req_mon.value,
                                                       req_mon.index));
         end
      end
      pending_count = awaited_results.size();
      model_fill    = fill;
   end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the sorted list engine: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;
   import sle_pkg::*;

   // Operation codes that the block has no use for.
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int RANDOM_OPS = 1250;
   localparam int LONG_HOLD  = 300;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } traffic_mode_type;

   logic clock;
   logic reset;

   sle_req_if req_chan();
   sle_rsp_if rsp_chan();

   int fail_count;
   int pending_count;
   int results_checked;
   int model_fill;
   int full_refusals;
   int bad_index_refusals;
   int find_hits;
   int replace_moves;

   int        ops_sent;
   int        spare_sent;
   bit        sender_steady;
   bit        receiver_steady;
   bit        hold_rsp;
   bit        hold_active;
   value_type value_pool[8];

   sorted_list_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sorted_list_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_chan),
      .rsp_mon            (rsp_chan),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .results_checked    (results_checked),
      .model_fill         (model_fill),
      .full_refusals      (full_refusals),
      .bad_index_refusals (bad_index_refusals),
      .find_hits          (find_hits),
      .replace_moves      (replace_moves)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net against a hung handshake.
   initial begin
      #10_000_000;
      $display("Run stopped by the time limit with %0d responses outstanding.", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

   // Idle lengths: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return value_pool[$urandom_range(0, 7)];
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0:       return value_type'(32'h7FFF_FFFF);
            1:       return value_type'(32'h8000_0000);
            2:       return value_type'(32'hFFFF_FFFF);
            default: return value_type'(32'h0000_0000);
         endcase
      end
      return value_type'($urandom);
   endfunction

   // Mostly a position that holds an entry, otherwise anything the field allows.
   function automatic logic [IDX_W-1:0] pick_index();
      if (model_fill > 0 && $urandom_range(0, 99) < 80)
         return IDX_W'($urandom_range(0, model_fill - 1));
      return IDX_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [OP_W-1:0] pick_op(traffic_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 70) return OP_INSERT;
            if (r < 78) return OP_REPLACE;
            if (r < 86) return OP_GET;
            if (r < 94) return OP_FIND;
            if (r < 98) return OP_REMOVE;
            if (r < 99) return OP_CLEAR;
         end
         MODE_DRAIN: begin
            if (r < 10) return OP_INSERT;
            if (r < 60) return OP_REMOVE;
            if (r < 72) return OP_REPLACE;
            if (r < 84) return OP_GET;
            if (r < 94) return OP_FIND;
            if (r < 97) return OP_CLEAR;
         end
         default: begin
            if (r < 30) return OP_INSERT;
            if (r < 45) return OP_REMOVE;
            if (r < 60) return OP_REPLACE;
            if (r < 75) return OP_GET;
            if (r < 92) return OP_FIND;
            if (r < 96) return OP_CLEAR;
         end
      endcase
      return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
   endfunction

   // Offers one request and returns at the falling edge after its transfer. Valid stays
   // high, so back-to-back requests need no second assignment in the same step.
   task automatic send_item(logic [OP_W-1:0] op, value_type v, logic [IDX_W-1:0] idx);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.operation <= op;
      req_chan.value     <= v;
      req_chan.index     <= idx;
      req_chan.valid     <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      if (op == OP_SPARE_6 || op == OP_SPARE_7) spare_sent++;
      else ops_sent++;
   endtask

   task automatic refresh_pool();
      for (int i = 0; i < 8; i++) begin
         if (i < 4) value_pool[i] = value_type'(int'($urandom_range(0, 40)) - 20);
         else value_pool[i] = value_type'($urandom);
      end
   endtask

   // Response side: random stalls, steady stretches and one long hold on request.
   initial begin
      int run_len;
      int stall_len;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_active = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp    = 1'b0;
            hold_active = 1'b0;
         end
         run_len = receiver_steady ? $urandom_range(30, 120) : $urandom_range(1, 16);
         rsp_chan.ready <= 1'b1;
         repeat (run_len) @(negedge clock);
         stall_len = receiver_steady ? 0 : pick_gap();
         if (stall_len > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   // Request side: reset, directed cases, then random traffic in segments.
   initial begin
      int               target;
      int               seg_len;
      traffic_mode_type mode;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_INSERT;
      req_chan.value     = '0;
      req_chan.index     = '0;
      ops_sent           = 0;
      spare_sent         = 0;
      sender_steady      = 1'b0;
      receiver_steady    = 1'b0;
      hold_rsp           = 1'b0;
      hold_active        = 1'b0;
      refresh_pool();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Operations on an empty list, including every index-based refusal.
      send_item(OP_FIND, value_type'(0), 4'd0);
      send_item(OP_GET, value_type'(0), 4'd0);
      send_item(OP_REMOVE, value_type'(0), 4'd0);
      send_item(OP_REPLACE, value_type'(5), 4'd0);
      // Extremes of the value range, and an equal value placed before its twin.
      send_item(OP_INSERT, value_type'(32'h7FFF_FFFF), 4'd0);
      send_item(OP_INSERT, value_type'(32'h8000_0000), 4'd0);
      send_item(OP_INSERT, value_type'(0), 4'd0);
      send_item(OP_INSERT, value_type'(0), 4'd0);
      send_item(OP_INSERT, value_type'(-1), 4'd0);
      send_item(OP_GET, value_type'(0), 4'd0);
      send_item(OP_GET, value_type'(0), 4'd4);
      send_item(OP_GET, value_type'(0), 4'd5);
      send_item(OP_FIND, value_type'(32'h8000_0000), 4'd0);
      send_item(OP_FIND, value_type'(1), 4'd0);
      send_item(OP_REPLACE, value_type'(32'h7FFF_FFFF), 4'd2);
      send_item(OP_REMOVE, value_type'(0), 4'd15);
      // Spare codes, one with no payload bit set and one with every payload bit set.
      send_item(OP_SPARE_6, value_type'(0), 4'd0);
      send_item(OP_SPARE_7, value_type'(-1), 4'd15);
      send_item(OP_REMOVE, value_type'(0), 4'd0);
      send_item(OP_CLEAR, value_type'(0), 4'd0);
      send_item(OP_GET, value_type'(0), 4'd0);

      target = ops_sent + RANDOM_OPS;

      // Long hold at the receiver while requests keep coming without a gap.
      hold_rsp = 1'b1;
      while (!hold_active) @(negedge clock);
      sender_steady = 1'b1;
      repeat (40) send_item(pick_op(MODE_FILL), pick_value(), pick_index());
      sender_steady = 1'b0;

      while (ops_sent < target) begin
         mode            = traffic_mode_type'($urandom_range(0, 2));
         seg_len         = $urandom_range(20, 60);
         sender_steady   = ($urandom_range(0, 99) < 15);
         receiver_steady = ($urandom_range(0, 99) < 15);
         refresh_pool();
         repeat (seg_len) send_item(pick_op(mode), pick_value(), pick_index());
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      req_chan.valid <= 1'b0;

      // Drain what is outstanding, then give any stray response time to show up.
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Sent %0d operations and %0d spare codes; %0d responses checked.",
               ops_sent, spare_sent, results_checked);
      $display("Seen: %0d full-list refusals, %0d bad-index refusals,",
               full_refusals, bad_index_refusals);
      $display("      %0d finds hit, %0d replaces.", find_hits, replace_moves);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
